/* rtl/fv_laplacian_link_accumulator_top_defines.svh */
// Assertion macros shared by the link accumulator RTL.
`ifndef FV_LAPLACIAN_LINK_ACCUMULATOR_TOP_DEFINES_SVH
`define FV_LAPLACIAN_LINK_ACCUMULATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FVL_ASSERT_IMPL(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("link accumulator check failed");

// Next-cycle implication, disabled while reset is high.
`define FVL_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("link accumulator check failed");

`endif

/* rtl/fvl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fvl_pkg;

  // Fixed-point format of every value field
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned IN_W     = 7 * DATA_W;
  localparam int unsigned DIFF_W   = DATA_W + 1;
  localparam int unsigned PROD_W   = 2 * DATA_W;
  localparam int unsigned QUO_W    = DATA_W;
  localparam int unsigned ADDR_W   = 3;

  // Register indexes, taken from paddr[2]
  localparam logic REG_GAMMA_MODE  = 1'b0;
  localparam logic REG_CONST_GAMMA = 1'b1;

  localparam logic [DATA_W-1:0] CONST_GAMMA_RST = DATA_W'(65536);

  // Divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_status_t;

endpackage
`default_nettype wire

/* rtl/fv_laplacian_link_accumulator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "fv_laplacian_link_accumulator_top_defines.svh"
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata: 7 x Q16.16 link fields, s_tlast: last_link
// m_*       out        m_tvalid/m_tready  m_tdata: lap_value, m_tuser: flags
// APB       in/out     psel/penable/pready gamma_mode @0x0, const_gamma @0x4
//
// s_tready is high only in idle, so one link is finished before the next is taken.
// Most of a link's time goes to the 32-step restoring divider, which a link with zero
// |r|^2 skips; one shared 33x32 multiplier serves all six products in turn.
// Reset (synchronous, active high) clears the sum and the flags and restores the registers.
// A pending result waits in the output register; the next link is taken meanwhile,
// and only a last link stalls at its end while that register is still full.
module fv_laplacian_link_accumulator_top (
  input  logic                        clk,
  input  logic                        rst,
  // Input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // value_here, value_across, dist_x, dist_y, normal_x, normal_y, face_gamma
  input  logic [fvl_pkg::IN_W-1:0]    s_tdata,
  input  logic                        s_tlast,
  // Result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // lap_value
  output logic [fvl_pkg::DATA_W-1:0]  m_tdata,
  // degenerate_seen, saturated
  output logic [1:0]                  m_tuser,
  // Configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fvl_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fvl_pkg::*;

  localparam int unsigned SAT_IN_W = PROD_W - FRAC_W;
  localparam logic [SAT_IN_W-1:0] NEG_LIM =
    {{(SAT_IN_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [SAT_IN_W-1:0] POS_LIM = NEG_LIM - 1'b1;
  localparam logic [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_DXX, S_DYY, S_DXN, S_DYN, S_DOT, S_DIVS, S_DIVW,
    S_COEF, S_TERM, S_TMUL, S_SUMT, S_ACC, S_FIN
  } state_t;

  state_t state;

  // Configuration registers
  logic              gamma_mode;
  logic [DATA_W-1:0] const_gamma;

  // Per-link operands, sign and magnitude
  logic              dx_neg, dy_neg, nx_neg, ny_neg, g_neg, diff_neg, last_q;
  logic [DATA_W-1:0] dx_mag, dy_mag, nx_mag, ny_mag, g_mag;
  logic [DIFF_W-1:0] diff_mag;

  // Intermediate results
  logic [PROD_W-1:0] mag2, t1, dot_mag;
  logic              dot_neg, r_neg, c_neg;
  logic [DATA_W-1:0] r_mag, c_mag, term;

  // Cell state
  logic [DATA_W-1:0] running_sum;
  logic              degenerate_flag, saturate_flag;

  // Shared units
  logic [DIFF_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  logic              div_start;
  logic [QUO_W-1:0]  div_q;
  div_status_t       div_st;

  // Combinational helpers
  logic [DATA_W-1:0] in_here, in_across, in_dx, in_dy, in_nx, in_ny, in_fg, in_g;
  logic [DIFF_W-1:0] in_diff;
  logic              t2_neg, t1_neg;
  logic [PROD_W-1:0] dot_sum;
  logic              dot_sum_neg;
  logic [SAT_IN_W-1:0] q_ext, c_ext, t_ext;
  logic              t_neg;
  logic [DATA_W:0]   acc_sum;
  logic              acc_ovf;
  logic              cfg_wr;
  logic              in_fire, out_free;

  function automatic logic [DATA_W-1:0] mag_of(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? DATA_W'(0) - v : v;
  endfunction

  function automatic logic [SAT_IN_W-1:0] lim_of(input logic neg);
    return neg ? NEG_LIM : POS_LIM;
  endfunction

  function automatic logic [DATA_W-1:0] clamp_mag(input logic neg,
                                                  input logic [SAT_IN_W-1:0] m);
    return (m > lim_of(neg)) ? DATA_W'(lim_of(neg)) : DATA_W'(m);
  endfunction

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_mode  <= 1'b0;
      const_gamma <= CONST_GAMMA_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_GAMMA_MODE:  gamma_mode  <= pwdata[0];
        REG_CONST_GAMMA: const_gamma <= pwdata[DATA_W-1:0];
        default:         gamma_mode  <= gamma_mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GAMMA_MODE:  prdata = {31'b0, gamma_mode};
      REG_CONST_GAMMA: prdata = const_gamma;
      default:         prdata = '0;
    endcase
  end

  // Unpack the input transaction
  assign in_here   = s_tdata[0*DATA_W +: DATA_W];
  assign in_across = s_tdata[1*DATA_W +: DATA_W];
  assign in_dx     = s_tdata[2*DATA_W +: DATA_W];
  assign in_dy     = s_tdata[3*DATA_W +: DATA_W];
  assign in_nx     = s_tdata[4*DATA_W +: DATA_W];
  assign in_ny     = s_tdata[5*DATA_W +: DATA_W];
  assign in_fg     = s_tdata[6*DATA_W +: DATA_W];
  assign in_g      = gamma_mode ? const_gamma : in_fg;
  assign in_diff   = {in_across[DATA_W-1], in_across} - {in_here[DATA_W-1], in_here};

  assign s_tready = (state == S_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (state)
      S_DXX:   begin mul_a = DIFF_W'(dx_mag);   mul_b = dx_mag; end
      S_DYY:   begin mul_a = DIFF_W'(dy_mag);   mul_b = dy_mag; end
      S_DXN:   begin mul_a = DIFF_W'(dx_mag);   mul_b = nx_mag; end
      S_DYN:   begin mul_a = DIFF_W'(dy_mag);   mul_b = ny_mag; end
      S_COEF:  begin mul_a = DIFF_W'(g_mag);    mul_b = r_mag;  end
      S_TMUL:  begin mul_a = diff_mag;          mul_b = c_mag;  end
      default: begin mul_a = '0;                mul_b = '0;     end
    endcase
  end

  // Sign-magnitude sum of the two dot-product terms
  assign t1_neg = dx_neg ^ nx_neg;
  assign t2_neg = dy_neg ^ ny_neg;
  always_comb begin
    if (t1_neg == t2_neg) begin
      dot_sum     = t1 + mul_p;
      dot_sum_neg = t1_neg;
    end else if (t1 >= mul_p) begin
      dot_sum     = t1 - mul_p;
      dot_sum_neg = t1_neg;
    end else begin
      dot_sum     = mul_p - t1;
      dot_sum_neg = t2_neg;
    end
  end

  // Magnitudes ahead of each clamp
  assign q_ext  = div_st.ovf ? {SAT_IN_W{1'b1}} : SAT_IN_W'(div_q);
  assign c_ext  = SAT_IN_W'(mul_p >> FRAC_W);
  assign t_ext  = SAT_IN_W'(mul_p >> FRAC_W);
  assign t_neg  = diff_neg ^ c_neg;

  // Running sum with signed clamp
  assign acc_sum = {running_sum[DATA_W-1], running_sum} + {term[DATA_W-1], term};
  assign acc_ovf = acc_sum[DATA_W] != acc_sum[DATA_W-1];

  assign div_start = (state == S_DIVS);

  fvl_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  fvl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dot_mag),
    .divisor  (mag2),
    .quotient (div_q),
    .status   (div_st)
  );

  // Sequencer, cell state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      running_sum     <= '0;
      degenerate_flag <= 1'b0;
      saturate_flag   <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      // Raise valid on a cell result, drop it once the transaction is taken
      if (state == S_FIN && last_q && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            dx_neg   <= in_dx[DATA_W-1];
            dy_neg   <= in_dy[DATA_W-1];
            nx_neg   <= in_nx[DATA_W-1];
            ny_neg   <= in_ny[DATA_W-1];
            g_neg    <= in_g[DATA_W-1];
            dx_mag   <= mag_of(in_dx);
            dy_mag   <= mag_of(in_dy);
            nx_mag   <= mag_of(in_nx);
            ny_mag   <= mag_of(in_ny);
            g_mag    <= mag_of(in_g);
            diff_neg <= in_diff[DIFF_W-1];
            diff_mag <= in_diff[DIFF_W-1] ? DIFF_W'(0) - in_diff : in_diff;
            last_q   <= s_tlast;
            state    <= S_DXX;
          end
        end
        S_DXX: state <= S_DYY;
        S_DYY: begin
          mag2  <= mul_p;
          state <= S_DXN;
        end
        S_DXN: begin
          mag2  <= mag2 + mul_p;
          state <= S_DYN;
        end
        S_DYN: begin
          t1    <= mul_p;
          state <= S_DOT;
        end
        S_DOT: begin
          dot_mag <= dot_sum;
          dot_neg <= dot_sum_neg;
          // Zero distance: skip the link and flag it
          if (mag2 == '0) begin
            degenerate_flag <= 1'b1;
            state           <= S_FIN;
          end else begin
            state <= S_DIVS;
          end
        end
        S_DIVS: state <= S_DIVW;
        S_DIVW: begin
          if (div_st.done) begin
            r_neg <= dot_neg;
            r_mag <= clamp_mag(dot_neg, q_ext);
            if (q_ext > lim_of(dot_neg)) saturate_flag <= 1'b1;
            state <= S_COEF;
          end
        end
        S_COEF: state <= S_TERM;
        S_TERM: begin
          c_neg <= g_neg ^ r_neg;
          c_mag <= clamp_mag(g_neg ^ r_neg, c_ext);
          if (c_ext > lim_of(g_neg ^ r_neg)) saturate_flag <= 1'b1;
          state <= S_TMUL;
        end
        S_TMUL: state <= S_SUMT;
        S_SUMT: begin
          term <= t_neg ? DATA_W'(0) - clamp_mag(t_neg, t_ext) : clamp_mag(t_neg, t_ext);
          if (t_ext > lim_of(t_neg)) saturate_flag <= 1'b1;
          state <= S_ACC;
        end
        S_ACC: begin
          if (acc_ovf) begin
            running_sum   <= acc_sum[DATA_W] ? S_MIN : S_MAX;
            saturate_flag <= 1'b1;
          end else begin
            running_sum <= acc_sum[DATA_W-1:0];
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (out_free) begin
            // Emit the cell result and clear the accumulator
            m_tdata         <= running_sum;
            m_tuser         <= {saturate_flag, degenerate_flag};
            running_sum     <= '0;
            degenerate_flag <= 1'b0;
            saturate_flag   <= 1'b0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FVL_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_fire, !s_tready)
  `FVL_ASSERT_IMPL(a_result_from_last, clk, rst, $rose(m_tvalid), $past(state == S_FIN && last_q))
  `FVL_ASSERT_IMPL(a_div_quiet_when_idle, clk, rst, state == S_IDLE, !div_st.busy)

endmodule
`default_nettype wire

/* rtl/fvl_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module fvl_mul (
  input  logic                        clk,
  input  logic [fvl_pkg::DIFF_W-1:0]  a,
  input  logic [fvl_pkg::DATA_W-1:0]  b,
  output logic [fvl_pkg::PROD_W-1:0]  p
);
  import fvl_pkg::*;

  logic [DIFF_W+DATA_W-1:0] full;

  // Unsigned magnitude product; operands never exceed 2^63 together
  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full[PROD_W-1:0];
  end

endmodule
`default_nettype wire

/* rtl/fvl_div.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "fv_laplacian_link_accumulator_top_defines.svh"
module fvl_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fvl_pkg::PROD_W-1:0]  dividend,
  input  logic [fvl_pkg::PROD_W-1:0]  divisor,
  output logic [fvl_pkg::QUO_W-1:0]   quotient,
  output fvl_pkg::div_status_t        status
);
  import fvl_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUO_W);
  localparam int unsigned CMP_W = PROD_W + QUO_W - FRAC_W;

  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] dsr;
  logic [QUO_W-1:0]  low;
  logic [CNT_W-1:0]  cnt;
  logic [PROD_W:0]   shifted;
  logic [PROD_W+1:0] trial;
  logic              take;
  logic              ovf_now;

  // Quotient of (dividend << FRAC_W) / divisor overflows QUO_W bits
  assign ovf_now = CMP_W'(dividend) >= {divisor, {(QUO_W-FRAC_W){1'b0}}};

  // Restoring step: shift in one dividend bit, subtract when it fits
  assign shifted = {rem, low[QUO_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr};
  assign take    = ~trial[PROD_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      if (start) begin
        rem         <= dividend >> (QUO_W - FRAC_W);
        low         <= QUO_W'(dividend << FRAC_W);
        dsr         <= divisor;
        status.ovf  <= ovf_now;
        status.busy <= 1'b1;
        status.done <= 1'b0;
        cnt         <= '0;
      end else if (status.busy) begin
        rem      <= take ? trial[PROD_W-1:0] : shifted[PROD_W-1:0];
        low      <= low << 1;
        quotient <= {quotient[QUO_W-2:0], take};
        cnt      <= cnt + 1'b1;
        // Finish on the last quotient bit
        status.done <= (cnt == CNT_W'(QUO_W - 1));
        if (cnt == CNT_W'(QUO_W - 1)) begin
          status.busy <= 1'b0;
        end
      end else begin
        status.done <= 1'b0;
      end
    end
  end

  `FVL_ASSERT_IMPL(a_div_start_idle, clk, rst, start, !status.busy)
  `FVL_ASSERT_IMPL(a_div_done_after_busy, clk, rst, $rose(status.done), $past(status.busy))

endmodule
`default_nettype wire

/* test/fv_laplacian_link_accumulator_checker.sv */
`timescale 1ns / 1ps
// Watches the link, result and register channels of the link accumulator,
// predicts each cell's Laplacian and compares it with what the block emits.
module fv_laplacian_link_accumulator_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  // value_here, value_across, dist_x, dist_y, normal_x, normal_y, face_gamma
  input  logic [fvl_pkg::IN_W-1:0]    s_tdata,
  input  logic                        s_tlast,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  // lap_value
  input  logic [fvl_pkg::DATA_W-1:0]  m_tdata,
  // degenerate_seen, saturated
  input  logic [1:0]                  m_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [fvl_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output int                          fail_count,
  output int                          pending
);

  localparam int FRAC = fvl_pkg::FRAC_W;
  localparam logic [127:0] POS_MAG = 128'h7FFF_FFFF;
  localparam logic [127:0] NEG_MAG = 128'h8000_0000;

  typedef struct packed {
    logic [31:0] lap;
    logic        deg;
    logic        sat;
  } cell_result_t;

  // Register copies
  logic               gain_from_reg;
  logic signed [31:0] const_gain;

  // Per-cell accumulator copy
  longint signed      cell_sum;
  logic               cell_degenerate;
  logic               cell_saturated;
  logic               link_clamped;

  cell_result_t       cell_results[$];

  function automatic logic [63:0] magnitude(input longint signed v);
    return v < 0 ? -v : v;
  endfunction

  // Clamp a sign-magnitude value to the 32-bit signed range
  function automatic longint signed clamp_sm(input logic neg, input logic [127:0] m);
    longint signed t;
    if (neg) begin
      if (m > NEG_MAG) begin
        m = NEG_MAG;
        link_clamped = 1'b1;
      end
    end else if (m > POS_MAG) begin
      m = POS_MAG;
      link_clamped = 1'b1;
    end
    t = m[63:0];
    return neg ? -t : t;
  endfunction

  // Fixed-point product on magnitudes, truncated toward zero, then clamped
  function automatic longint signed fx_product(input longint signed a, input longint signed b);
    logic [127:0] m;
    m = (128'(magnitude(a)) * 128'(magnitude(b))) >> FRAC;
    return clamp_sm((a < 0) != (b < 0), m);
  endfunction

  // Add one link's two-point flux term to the cell sum; a last link queues the cell result
  task automatic accumulate_link(input logic [fvl_pkg::IN_W-1:0] d, input logic last);
    longint signed here, across, dx, dy, nx, ny, gain;
    longint signed ratio, coeff, term, total;
    logic [127:0]  mag2, px, py, dot, dmag, quo;
    logic          dneg;
    cell_result_t  res;
    here   = $signed(d[31:0]);
    across = $signed(d[63:32]);
    dx     = $signed(d[95:64]);
    dy     = $signed(d[127:96]);
    nx     = $signed(d[159:128]);
    ny     = $signed(d[191:160]);
    gain   = gain_from_reg ? longint'(const_gain) : longint'($signed(d[223:192]));
    link_clamped = 1'b0;
    mag2 = 128'(magnitude(dx)) * 128'(magnitude(dx)) +
           128'(magnitude(dy)) * 128'(magnitude(dy));
    if (mag2 == 0) begin
      cell_degenerate = 1'b1;
    end else begin
      px = 128'(magnitude(dx)) * 128'(magnitude(nx));
      py = 128'(magnitude(dy)) * 128'(magnitude(ny));
      dot = (((dx < 0) != (nx < 0)) ? -px : px) + (((dy < 0) != (ny < 0)) ? -py : py);
      dneg = dot[127];
      dmag = dneg ? -dot : dot;
      quo = (dmag << FRAC) / mag2;
      ratio = clamp_sm(dneg, quo);
      coeff = fx_product(gain, ratio);
      term = fx_product(across - here, coeff);
      total = cell_sum + term;
      if (total > longint'(POS_MAG)) begin
        total = longint'(POS_MAG);
        link_clamped = 1'b1;
      end else if (total < -longint'(NEG_MAG)) begin
        total = -longint'(NEG_MAG);
        link_clamped = 1'b1;
      end
      cell_sum = total;
    end
    if (link_clamped) cell_saturated = 1'b1;
    if (last) begin
      res.lap = cell_sum[31:0];
      res.deg = cell_degenerate;
      res.sat = cell_saturated;
      cell_results.push_back(res);
      cell_sum = 0;
      cell_degenerate = 1'b0;
      cell_saturated = 1'b0;
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      gain_from_reg = 1'b0;
      const_gain = fvl_pkg::CONST_GAMMA_RST;
      cell_sum = 0;
      cell_degenerate = 1'b0;
      cell_saturated = 1'b0;
      cell_results.delete();
    end else begin
      // Compare a finished cell with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (cell_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got lap %h flags %b",
                   $time, m_tdata, m_tuser);
          fail_count = fail_count + 1;
        end else begin
          want = cell_results.pop_front();
          if (m_tdata !== want.lap) begin
            $display("%0t: lap_value expected %h, got %h", $time, want.lap, m_tdata);
            fail_count = fail_count + 1;
          end
          if (m_tuser[0] !== want.deg) begin
            $display("%0t: degenerate_seen expected %b, got %b", $time, want.deg, m_tuser[0]);
            fail_count = fail_count + 1;
          end
          if (m_tuser[1] !== want.sat) begin
            $display("%0t: saturated expected %b, got %b", $time, want.sat, m_tuser[1]);
            fail_count = fail_count + 1;
          end
        end
      end
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == fvl_pkg::REG_GAMMA_MODE) gain_from_reg = pwdata[0];
        else if (paddr[2] == fvl_pkg::REG_CONST_GAMMA) const_gain = pwdata;
      end
      if (s_tvalid && s_tready) accumulate_link(s_tdata, s_tlast);
    end
    pending = cell_results.size();
  end

endmodule

/* test/fv_laplacian_link_accumulator_top_test.sv */
`timescale 1ns / 1ps
// Drives links and register writes into the link accumulator and gives the verdict.
module fv_laplacian_link_accumulator_top_test;

  localparam logic [31:0] Q_ONE = 32'h0001_0000;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;
  localparam logic [fvl_pkg::ADDR_W-1:0] ADDR_GAMMA_MODE = {fvl_pkg::REG_GAMMA_MODE, 2'b00};
  localparam logic [fvl_pkg::ADDR_W-1:0] ADDR_CONST_GAMMA = {fvl_pkg::REG_CONST_GAMMA, 2'b00};
  localparam int SETTLE_CYCLES = 60;

  typedef struct packed {
    logic [31:0] face_gamma;
    logic [31:0] normal_y;
    logic [31:0] normal_x;
    logic [31:0] dist_y;
    logic [31:0] dist_x;
    logic [31:0] value_across;
    logic [31:0] value_here;
  } link_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [fvl_pkg::IN_W-1:0]    s_tdata = '0;
  logic                        s_tlast = 1'b0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [fvl_pkg::DATA_W-1:0]  m_tdata;
  logic [1:0]                  m_tuser;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [fvl_pkg::ADDR_W-1:0]  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  int fail_count;
  int pending;

  // Traffic shaping shared by the sender and the receiver
  bit calm = 1'b0;
  bit send_bursty = 1'b1;
  int links_sent = 0;
  int long_holds = 0;

  fv_laplacian_link_accumulator_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  fv_laplacian_link_accumulator_checker flux_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result backpressure: random stall bursts, calm stretches and long hold-offs
  always @(negedge clk) begin
    static int hold_left = 0;
    static int stall_left = 0;
    static int span_left = 0;
    static int holds_taken = 0;
    static bit ready_bursty = 1'b1;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holds_taken != long_holds) begin
      holds_taken = long_holds;
      hold_left = 700;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (!calm && ready_bursty && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 14);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
    if (span_left == 0) begin
      span_left = $urandom_range(50, 300);
      ready_bursty = $urandom_range(0, 2) != 0;
    end else begin
      span_left = span_left - 1;
    end
  end

  function automatic link_t make_link(input logic [31:0] here, across, dx, dy, nx, ny, g);
    link_t l;
    l.value_here = here;
    l.value_across = across;
    l.dist_x = dx;
    l.dist_y = dy;
    l.normal_x = nx;
    l.normal_y = ny;
    l.face_gamma = g;
    return l;
  endfunction

  // Random Q16.16 value: mostly moderate, some full-range, some extremes
  function automatic logic [31:0] pick_fx();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $urandom();
      3: begin
        case ($urandom_range(0, 4))
          0: v = Q_MIN;
          1: v = Q_MAX;
          2: v = 32'h0;
          3: v = 32'h1;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      default: begin
        v = $urandom_range(0, 32'h0008_0000);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic link_t random_link();
    link_t l;
    l = make_link(pick_fx(), pick_fx(), pick_fx(), pick_fx(), pick_fx(), pick_fx(), pick_fx());
    case ($urandom_range(0, 19))
      0, 1: begin
        l.dist_x = 32'h0;
        l.dist_y = 32'h0;
      end
      2: l.dist_y = 32'h0;
      3: l.dist_x = 32'h0;
      default: ;
    endcase
    return l;
  endfunction

  // Offer one link; called at a falling edge, returns at the falling edge after acceptance
  task automatic send_link(input link_t l, input logic last);
    if (links_sent % 40 == 0) send_bursty = $urandom_range(0, 2) != 0;
    if (!calm && send_bursty && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tdata <= l;
    s_tlast <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    links_sent = links_sent + 1;
    @(negedge clk);
  endtask

  // One write transaction, then the bus is left idle before the task returns
  task automatic apb_write(input logic [fvl_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for every predicted result, then let a trailing non-last link finish
  task automatic drain();
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One segment of random cells under one register setting
  task automatic run_cells(input int count, input bit want_hold, input bit want_pause);
    int stop_at;
    int links;
    int k;
    stop_at = links_sent + count;
    while (links_sent < stop_at) begin
      if (want_hold && links_sent + count - stop_at > 40) begin
        long_holds = long_holds + 1;
        want_hold = 1'b0;
      end
      if (want_pause && links_sent + count - stop_at > 100) begin
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        want_pause = 1'b0;
      end
      if ($urandom_range(0, 19) == 0) begin
        // Noise: a stray link with a random last marker
        send_link(random_link(), 1'($urandom_range(0, 1)));
      end else begin
        links = $urandom_range(1, 6);
        for (k = 0; k < links; k++) send_link(random_link(), k == links - 1);
      end
    end
    // Close any open cell so the segment ends on a result
    send_link(random_link(), 1'b1);
  endtask

  initial begin
    int seg;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed links under reset registers (per-link diffusivity)
    send_link(make_link(Q_ONE, 32'h0003_0000, 32'h0, 32'h0, Q_ONE, Q_ONE, Q_ONE), 1'b1);
    send_link(make_link(Q_ONE, 32'h0002_0000, Q_ONE, 32'h0, Q_ONE, 32'h0, Q_ONE), 1'b0);
    send_link(make_link(Q_ONE, 32'h0, -Q_ONE, 32'h0, -Q_ONE, 32'h0, Q_ONE), 1'b0);
    send_link(make_link(Q_ONE, 32'h0003_0000, 32'h0, Q_ONE, 32'h0, Q_ONE, Q_ONE), 1'b0);
    send_link(make_link(Q_ONE, Q_ONE, 32'h0, -Q_ONE, 32'h0, -Q_ONE, 32'h0001_8000), 1'b1);
    send_link(make_link(Q_MIN, Q_MAX, Q_ONE, 32'h0, Q_MAX, Q_MIN, Q_MAX), 1'b1);
    send_link(make_link(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN), 1'b1);
    send_link(make_link(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1);
    // Quotient overflow from a tiny distance
    send_link(make_link(32'h0, Q_ONE, 32'h1, 32'h0, Q_MAX, 32'h0, 32'h1), 1'b1);
    send_link(make_link(Q_ONE, 32'h0, Q_ONE, Q_ONE, Q_ONE, 32'h0, Q_MIN), 1'b1);
    // Sum overflow across several links
    send_link(make_link(32'h0, 32'h4000_0000, Q_ONE, 32'h0, Q_ONE, 32'h0, Q_ONE), 1'b0);
    send_link(make_link(32'h0, 32'h4000_0000, Q_ONE, 32'h0, Q_ONE, 32'h0, Q_ONE), 1'b0);
    send_link(make_link(32'h0, 32'h4000_0000, Q_ONE, 32'h0, Q_ONE, 32'h0, Q_ONE), 1'b0);
    send_link(make_link(Q_MIN, Q_MAX, Q_ONE, 32'h0, -Q_ONE, 32'h0, Q_ONE), 1'b1);
    send_link(make_link(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0), 1'b1);
    // Degenerate link opening a two-link cell
    send_link(make_link(Q_ONE, 32'h0005_0000, 32'h0, 32'h0, Q_ONE, Q_ONE, Q_ONE), 1'b0);
    send_link(make_link(Q_ONE, 32'h0005_0000, 32'h0000_8000, 32'h0, Q_ONE, 32'h0, Q_ONE), 1'b1);
    send_link(make_link(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b1);
    // Leave a cell open across a register change
    send_link(make_link(32'h0, Q_ONE, Q_ONE, 32'h0, Q_ONE, 32'h0, 32'h0002_0000), 1'b0);
    drain();

    // Constant diffusivity at its extremes
    apb_write(ADDR_GAMMA_MODE, 32'h1);
    apb_write(ADDR_CONST_GAMMA, Q_MAX);
    send_link(make_link(32'h0, Q_ONE, Q_ONE, 32'h0, Q_ONE, 32'h0, 32'h0), 1'b1);
    send_link(make_link(Q_ONE, 32'h0, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE), 1'b1);
    drain();
    apb_write(ADDR_CONST_GAMMA, Q_MIN);
    send_link(make_link(32'h0, Q_ONE, Q_ONE, 32'h0, Q_ONE, 32'h0, Q_ONE), 1'b1);
    send_link(make_link(Q_MAX, Q_MIN, 32'h0000_0100, 32'h0, Q_ONE, 32'h0, Q_ONE), 1'b1);
    drain();

    // Random cells under a sequence of register settings
    for (seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin
          apb_write(ADDR_GAMMA_MODE, 32'h0);
          apb_write(ADDR_CONST_GAMMA, fvl_pkg::CONST_GAMMA_RST);
        end
        1: begin
          apb_write(ADDR_GAMMA_MODE, 32'h1);
        end
        2: begin
          apb_write(ADDR_CONST_GAMMA, 32'h0);
        end
        3: begin
          apb_write(ADDR_CONST_GAMMA, $urandom());
        end
        4: begin
          apb_write(ADDR_GAMMA_MODE, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0});
          apb_write(ADDR_CONST_GAMMA, Q_MIN);
        end
        default: begin
          apb_write(ADDR_GAMMA_MODE, 32'hFFFF_FFFF);
          apb_write(ADDR_CONST_GAMMA, -32'h0002_8000);
          calm = 1'b1;
        end
      endcase
      run_cells(250, seg == 1, seg == 3);
      drain();
    end

    // Final settle, then verdict
    repeat (100) @(negedge clk);
    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/fvl_pkg.sv
rtl/fvl_mul.sv
rtl/fvl_div.sv
rtl/fv_laplacian_link_accumulator_top.sv
test/fv_laplacian_link_accumulator_checker.sv
test/fv_laplacian_link_accumulator_top_test.sv
